### hw/rtl/fcce_pkg.sv
// Shared types and constants of the cluster link table engine.
`timescale 1ns / 1ps
package fcce_pkg;

    // Request codes
    localparam logic [2:0] REQ_READ   = 3'd0;
    localparam logic [2:0] REQ_WRITE  = 3'd1;
    localparam logic [2:0] REQ_WALK   = 3'd2;
    localparam logic [2:0] REQ_FREE   = 3'd3;
    localparam logic [2:0] REQ_APPEND = 3'd4;
    localparam logic [2:0] REQ_INIT   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LOOP  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_COUNT = 2'd0;
    localparam logic [1:0] CFG_FREE  = 2'd1;
    localparam logic [1:0] CFG_END   = 2'd2;

    // Longest chain reported
    localparam int unsigned MAX_RESULTS = 64;

    // Classified request between front and back
    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] first;
        logic [31:0] second;
        logic        err;     // reject at once with err_st
        logic [1:0]  err_st;
        logic        a_mark;  // first is a marker (append)
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        last;
    } t_res;

endpackage

### hw/rtl/fcce_front.sv
// Front end: accepts requests, checks ranges and markers, queues commands.
`timescale 1ns / 1ps
module fcce_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_req,
    input  logic [31:0]          i_first,
    input  logic [31:0]          i_second,
    input  logic [6:0]           i_n,
    input  logic [31:0]          i_free,
    input  logic [31:0]          i_end,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output fcce_pkg::t_cmd       o_cmd
);
    import fcce_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_c;
    logic       w_a_oor, w_b_oor, w_a_mk, w_b_mk, w_push, w_pop;

    // Classify the incoming request
    always_comb begin
        w_a_oor = (i_first >= {25'd0, i_n});
        w_b_oor = (i_second >= {25'd0, i_n});
        w_a_mk  = (i_first == i_free) || (i_first == i_end);
        w_b_mk  = (i_second == i_free) || (i_second == i_end);
        w_c.req    = i_req;
        w_c.first  = i_first;
        w_c.second = i_second;
        w_c.a_mark = w_a_mk;
        w_c.err    = 1'b0;
        w_c.err_st = ST_RANGE;
        priority case (i_req)
            REQ_READ, REQ_WRITE: w_c.err = w_a_oor;
            REQ_WALK, REQ_FREE: begin
                if (i_n == 7'd0) begin
                    w_c.err = 1'b1;
                end else if (w_a_mk || w_a_oor) begin
                    w_c.err = 1'b1;
                    w_c.err_st = ST_EMPTY;
                end
            end
            REQ_APPEND: w_c.err = w_a_oor || w_b_mk || w_b_oor;
            REQ_INIT:   w_c.err = (i_n == 7'd0);
            default:    w_c.err = 1'b1;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(QD));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_c;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QD))
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("push not counted");

endmodule

### hw/rtl/fcce_back.sv
// Back end: sequencer over the link memory that carries out each command.
`timescale 1ns / 1ps
module fcce_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  fcce_pkg::t_cmd       i_cmd,
    input  logic [6:0]           i_n,
    input  logic [31:0]          i_free,
    input  logic [31:0]          i_end,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output fcce_pkg::t_res       o_res
);
    import fcce_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_CHK, S_CHKW, S_EMIT, S_EMITW, S_FREE, S_FREEW,
        S_APP, S_INIT, S_OUT
    } t_state;

    logic [31:0] r_mem [TABLE_DEPTH];
    logic [31:0] r_rdata;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [31:0] r_cur;
    logic [6:0]  r_len;
    logic [AW-1:0] r_idx;
    logic        r_res_valid;
    t_res        r_res;

    logic          w_we, w_re;
    logic [AW-1:0] w_wa, w_ra;
    logic [31:0]   w_wd;
    logic          w_stop_rd, w_stop_cur;

    // Chain ends at a marker or an index out of range
    assign w_stop_rd  = (r_rdata == i_end) || (r_rdata == i_free)
                     || (r_rdata >= {25'd0, i_n});
    assign w_stop_cur = (r_cur == i_end) || (r_cur == i_free)
                     || (r_cur >= {25'd0, i_n});

    assign o_cmd_ready = (r_state == S_IDLE) && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Memory port control
    always_comb begin
        w_we = 1'b0; w_wa = r_idx; w_wd = i_free;
        w_re = 1'b0; w_ra = r_cur[AW-1:0];
        unique case (r_state)
            S_RD:   begin w_re = 1'b1; w_ra = r_cmd.first[AW-1:0]; end
            S_CHK, S_EMIT, S_FREE: w_re = 1'b1;
            S_FREEW: begin w_we = 1'b1; w_wa = r_cur[AW-1:0]; end
            S_INIT: w_we = 1'b1;
            default: ;
        endcase
        if (r_state == S_RD && r_cmd.req == REQ_WRITE) begin
            w_re = 1'b0; w_we = 1'b1;
            w_wa = r_cmd.first[AW-1:0]; w_wd = r_cmd.second;
        end
        if (r_state == S_APP) begin
            w_we = 1'b1;
            if (r_len == 7'd0) begin
                w_wa = r_cmd.second[AW-1:0]; w_wd = i_end;
            end else begin
                w_wa = r_cmd.first[AW-1:0]; w_wd = r_cmd.second;
            end
        end
    end

    // Link memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rdata <= r_mem[w_ra];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd <= i_cmd;
                        r_cur <= i_cmd.first;
                        r_len <= '0;
                        r_idx <= '0;
                        r_res <= '{status: (i_cmd.err ? i_cmd.err_st : ST_OK),
                                   data: 32'd0, last: 1'b1};
                        if (i_cmd.err) begin
                            r_state <= S_OUT;
                        end else begin
                            priority case (i_cmd.req)
                                REQ_READ, REQ_WRITE: r_state <= S_RD;
                                REQ_APPEND:          r_state <= S_APP;
                                REQ_INIT:            r_state <= S_INIT;
                                default:             r_state <= S_CHK;
                            endcase
                        end
                    end
                end
                S_RD: r_state <= (r_cmd.req == REQ_WRITE) ? S_OUT : S_RDW;
                S_RDW: begin
                    r_res.data <= r_rdata;
                    r_state <= S_OUT;
                end
                // Pass one: measure the chain for loops
                S_CHK: begin
                    r_len <= r_len + 7'd1;
                    r_state <= S_CHKW;
                end
                S_CHKW: begin
                    if (r_len > i_n) begin
                        r_res.status <= ST_LOOP;
                        r_state <= S_OUT;
                    end else if (w_stop_rd) begin
                        r_cur <= r_cmd.first;
                        r_state <= (r_cmd.req == REQ_FREE) ? S_FREE : S_EMIT;
                    end else begin
                        r_cur <= r_rdata;
                        r_state <= S_CHK;
                    end
                end
                // Pass two: emit each cluster
                S_EMIT: if (!r_res_valid || i_res_ready) r_state <= S_EMITW;
                S_EMITW: begin
                    r_res_valid <= 1'b1;
                    r_res <= '{status: ST_OK, data: r_cur, last: w_stop_rd};
                    r_cur <= r_rdata;
                    r_state <= w_stop_rd ? S_IDLE : S_EMIT;
                end
                // Pass two: free each link after reading its successor
                S_FREE: r_state <= S_FREEW;
                S_FREEW: begin
                    r_cur <= r_rdata;
                    r_state <= w_stop_rd ? S_OUT : S_FREE;
                end
                S_APP: begin
                    r_len <= 7'd1;
                    if (r_len != 7'd0 || r_cmd.a_mark) r_state <= S_OUT;
                end
                S_INIT: begin
                    if ({25'd0, i_n} == 32'(r_idx) + 32'd1 || r_idx == AW'(TABLE_DEPTH - 1))
                    begin
                        if (r_cmd.second != 32'd0 && r_cmd.first < {25'd0, i_n}) begin
                            r_cmd.req <= REQ_WRITE;
                            r_cmd.second <= i_end;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_OUT: if (!r_res_valid) begin
                    r_res_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHKW) |-> (r_len <= i_n + 7'd1)) else $error("walk overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> o_res_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMITW) |-> !w_stop_cur) else $error("emitting a marker");

endmodule

### hw/rtl/fat_cluster_chain_engine.sv
// Top level of the cluster link table engine.
`timescale 1ns / 1ps
// Requests enter a two-deep queue and are carried out one at a time over a
// single-port link memory with a registered read. Initialize writes the free
// marker to each entry and then, when a root is asked for, marks it with the
// end marker. Walk and free first measure the chain to catch loops, then emit
// or free it; a stalled result output holds the emit pass. The back end takes
// the next request only after the previous result has been taken. Entries are
// undefined until written; reset does not clear them.
module fat_cluster_chain_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // first_cluster[31:0], second_value[63:32]
    input  logic [2:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // data
    output logic [1:0]  m_axis_tuser,  // status
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fcce_pkg::*;

    localparam int CAP = (TABLE_DEPTH < int'(MAX_RESULTS)) ? TABLE_DEPTH : int'(MAX_RESULTS);

    logic [6:0]  r_count;
    logic [31:0] r_free, r_end;
    logic [6:0]  w_n;
    logic        w_cv, w_cr;
    t_cmd        w_cmd;
    t_res        w_res;

    assign o_cfg_ready = 1'b1;
    assign w_n = (r_count > 7'(CAP)) ? 7'(CAP) : r_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 7'd64; r_free <= 32'd0; r_end <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COUNT: r_count <= i_cfg_data[6:0];
                CFG_FREE:  r_free  <= i_cfg_data;
                CFG_END:   r_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fcce_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req(s_axis_tuser), .i_first(s_axis_tdata[31:0]),
        .i_second(s_axis_tdata[63:32]),
        .i_n(w_n), .i_free(r_free), .i_end(r_end),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd(w_cmd)
    );

    fcce_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd(w_cmd),
        .i_n(w_n), .i_free(r_free), .i_end(r_end),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = w_res.data;
    assign m_axis_tuser = w_res.status;
    assign m_axis_tlast = w_res.last;

endmodule

### tb/sv/tb_fat_cluster_chain_engine.sv
// Testbench of the cluster link table engine: scoreboard class, stimulus and checks.
`timescale 1ns / 1ps
module tb_fat_cluster_chain_engine;
    import fcce_pkg::*;

    localparam int DEPTH         = 64;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 366;

    // Predicts the results of each request from its own copy of the link table
    class chain_scoreboard;
        logic [31:0] links [DEPTH];
        logic [6:0]  count_reg;
        logic [31:0] free_val;
        logic [31:0] end_val;
        t_res        expected_q[$];
        int          mismatches;

        function new();
            count_reg  = 7'd64;
            free_val   = 32'h0;
            end_val    = 32'hFFFF_FFFF;
            mismatches = 0;
            foreach (links[i]) links[i] = 32'h0;
        endfunction

        function int unsigned eff_count();
            return (count_reg > DEPTH) ? DEPTH : count_reg;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_COUNT: count_reg = val[6:0];
                CFG_FREE:  free_val  = val;
                CFG_END:   end_val   = val;
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] st, logic [31:0] dat, logic lst);
            t_res r;
            r.status = st;
            r.data   = dat;
            r.last   = lst;
            expected_q = {expected_q, r};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Note an accepted request and queue the results it must cause
        function void note_request(logic [2:0] req, logic [31:0] a, logic [31:0] b);
            int unsigned n;
            logic [31:0] cur;
            logic [31:0] path[$];
            bit          looped;
            n = eff_count();
            case (req)
                REQ_READ: begin
                    if (a >= n) push(ST_RANGE, 0, 1);
                    else push(ST_OK, links[a[5:0]], 1);
                end
                REQ_WRITE: begin
                    if (a >= n) push(ST_RANGE, 0, 1);
                    else begin
                        links[a[5:0]] = b;
                        push(ST_OK, 0, 1);
                    end
                end
                REQ_WALK, REQ_FREE: begin
                    if (n == 0) push(ST_RANGE, 0, 1);
                    else if (a == free_val || a == end_val || a >= n) push(ST_EMPTY, 0, 1);
                    else begin
                        cur    = a;
                        looped = 0;
                        while (cur != end_val && cur != free_val && cur < n) begin
                            path = {path, cur};
                            cur = links[cur[5:0]];
                            if (path.size() > n) begin
                                looped = 1;
                                break;
                            end
                        end
                        if (looped) push(ST_LOOP, 0, 1);
                        else if (req == REQ_FREE) begin
                            foreach (path[k]) links[path[k][5:0]] = free_val;
                            push(ST_OK, 0, 1);
                        end else begin
                            foreach (path[k]) push(ST_OK, path[k], k == path.size() - 1);
                        end
                    end
                end
                REQ_APPEND: begin
                    if (a >= n || b == free_val || b == end_val || b >= n)
                        push(ST_RANGE, 0, 1);
                    else begin
                        links[b[5:0]] = end_val;
                        if (a != free_val && a != end_val) links[a[5:0]] = b;
                        push(ST_OK, 0, 1);
                    end
                end
                REQ_INIT: begin
                    if (n == 0) push(ST_RANGE, 0, 1);
                    else begin
                        for (int unsigned i = 0; i < n; i++) links[i] = free_val;
                        if (b != 0 && a < n) links[a[5:0]] = end_val;
                        push(ST_OK, 0, 1);
                    end
                end
                default: push(ST_RANGE, 0, 1);
            endcase
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d data %h last %0d",
                             got.status, got.data, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.data !== want.data
                    || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st %0d data %h last %0d, got st %0d data %h last %0d",
                             want.status, want.data, want.last,
                             got.status, got.data, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    chain_scoreboard sb;
    bit          idle_on;
    bit          hold_due;
    int          stall_cycles;
    int          sent_items;
    int unsigned cur_n;
    logic [31:0] cur_free;
    logic [31:0] cur_end;
    logic [31:0] chain_tail;

    fat_cluster_chain_engine #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drain results with random back-pressure and one long hold-off
    initial begin
        int stall;
        t_res got;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 18) : 0;
            if (hold_due) begin
                stall    = 500;
                hold_due = 0;
            end
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.status = m_axis_tuser;
            got.data   = m_axis_tdata;
            got.last   = m_axis_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_request(logic [2:0] req, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = req;
        s_axis_tdata  = {b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, a, b);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Wait for every expected result, then let the block settle
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [6:0] cnt, logic [31:0] fv, logic [31:0] ev);
        drain();
        write_reg(CFG_COUNT, {25'h0, cnt});
        write_reg(CFG_FREE, fv);
        write_reg(CFG_END, ev);
        cur_n    = (cnt > DEPTH) ? DEPTH : cnt;
        cur_free = fv;
        cur_end  = ev;
    endtask

    // Mostly in-range indexes, some markers, some arbitrary words
    function automatic logic [31:0] pick_index();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return (cur_n > 0) ? $urandom_range(0, cur_n - 1) : 0;
        if (sel == 7) return cur_free;
        if (sel == 8) return cur_end;
        return $urandom;
    endfunction

    task automatic random_request();
        int sel;
        logic [31:0] nxt;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            // grow the current chain by one cluster
            nxt = pick_index();
            send_request(REQ_APPEND, chain_tail, nxt);
            if (nxt < cur_n && nxt != cur_free && nxt != cur_end) chain_tail = nxt;
        end else if (sel < 55) send_request(REQ_WALK, pick_index(), $urandom);
        else if (sel < 63) send_request(REQ_FREE, pick_index(), $urandom);
        else if (sel < 75) send_request(REQ_READ, pick_index(), $urandom);
        else if (sel < 87) send_request(REQ_WRITE, pick_index(), pick_index());
        else if (sel < 92) begin
            chain_tail = pick_index();
            send_request(REQ_INIT, chain_tail, $urandom_range(0, 1) ? $urandom : 0);
        end else if (sel < 95) send_request(3'($urandom_range(6, 7)), $urandom, $urandom);
        else if (sel < 97 && cur_n > 1) begin
            // full-length chain, its last link set at random to the end marker or to index 0
            for (int unsigned i = 0; i + 1 < cur_n; i++) send_request(REQ_WRITE, i, i + 1);
            send_request(REQ_WRITE, cur_n - 1, $urandom_range(0, 1) ? cur_end : 0);
            send_request(REQ_WALK, 0, 0);
        end else send_request(3'($urandom_range(0, 7)), $urandom, $urandom);
    endtask

    initial begin
        logic [6:0]  cnt_set [6] = '{7'd127, 7'd5, 7'd0, 7'd1, 7'd64, 7'd40};
        logic [31:0] free_set[6] = '{32'hFFFF_FFFF, 32'd3, 32'd0, 32'd7,
                                     32'h1234_5678, 32'd0};
        logic [31:0] end_set [6] = '{32'd0, 32'd4, 32'hFFFF_FFFF, 32'd8,
                                     32'hFFFF_FFFF, 32'h8000_0000};
        int          phase_goal;
        sb            = new();
        idle_on       = 1;
        hold_due      = 0;
        stall_cycles  = 0;
        sent_items    = 0;
        cur_n         = DEPTH;
        cur_free      = 32'h0;
        cur_end       = 32'hFFFF_FFFF;
        chain_tail    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_READ;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_COUNT;
        i_cfg_data    = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: define the whole table first, then corner cases
        send_request(REQ_INIT, 0, 1);
        send_request(REQ_APPEND, 0, 1);
        send_request(REQ_APPEND, 1, 2);
        send_request(REQ_WALK, 0, 0);
        send_request(REQ_READ, 2, 0);
        send_request(REQ_READ, 63, 0);
        send_request(REQ_READ, 64, 0);
        send_request(REQ_READ, 32'hFFFF_FFFF, 0);
        send_request(REQ_WRITE, 32'hFFFF_FFFF, 5);
        send_request(REQ_WRITE, 63, 32'h8000_0000);
        send_request(REQ_WRITE, 5, 5);
        send_request(REQ_WALK, 5, 0);
        send_request(REQ_FREE, 5, 0);
        send_request(REQ_APPEND, 7, 7);
        send_request(REQ_WALK, 7, 0);
        send_request(REQ_APPEND, 32'hFFFF_FFFF, 9);
        send_request(REQ_APPEND, 2, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 2, 0);
        send_request(REQ_APPEND, 64, 3);
        send_request(REQ_WALK, 32'hFFFF_FFFF, 0);
        send_request(REQ_WALK, 64, 0);
        send_request(REQ_WALK, 10, 0);
        send_request(REQ_FREE, 0, 0);
        send_request(3'd6, 1, 1);
        send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_INIT, 100, 1);

        // Random phases over several register settings
        for (int p = 0; p < 6; p++) begin
            configure(cnt_set[p], free_set[p], end_set[p]);
            chain_tail = (cur_n > 0) ? $urandom_range(0, cur_n - 1) : 0;
            send_request(REQ_INIT, chain_tail, 1);
            phase_goal = sent_items + RANDOM_ITEMS / 6;
            for (int i = 0; sent_items < phase_goal; i++) begin
                if (i % 20 == 0) idle_on = ($urandom_range(0, 3) != 0);
                if (p == 4 && i == 10) begin
                    idle_on  = 0;
                    hold_due = 1;
                end
                random_request();
            end
        end
        configure(7'd64, 32'h0, 32'hFFFF_FFFF);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/fcce_pkg.sv
hw/rtl/fcce_front.sv
hw/rtl/fcce_back.sv
hw/rtl/fat_cluster_chain_engine.sv
tb/sv/tb_fat_cluster_chain_engine.sv
